@@ rtl/core/udp_link_session_keepalive_fsm_macros.svh @@
// Assertion helpers shared by the session controller RTL
`ifndef UDP_LINK_SESSION_KEEPALIVE_FSM_MACROS_SVH
`define UDP_LINK_SESSION_KEEPALIVE_FSM_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset
`define ULSK_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset
`define ULSK_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/ulsk_pkg.sv @@
package ulsk_pkg;

   // link states
   localparam logic [2:0] ST_NONEXIST   = 3'd0;
   localparam logic [2:0] ST_INIT       = 3'd1;
   localparam logic [2:0] ST_CONNECTING = 3'd2;
   localparam logic [2:0] ST_CONNECTED  = 3'd3;
   localparam logic [2:0] ST_OPEN       = 3'd4;
   localparam logic [2:0] ST_CLOSING    = 3'd5;
   localparam logic [2:0] ST_CLOSED     = 3'd6;
   localparam logic [2:0] ST_BROKEN     = 3'd7;

   // event kinds
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_CTRL  = 2'd1;
   localparam logic [1:0] KIND_DATA  = 2'd2;
   localparam logic [1:0] KIND_CLOSE = 2'd3;

   // received control codes
   localparam logic [2:0] MSG_REQ_CONNECT = 3'd0;
   localparam logic [2:0] MSG_NTF_CONNECT = 3'd1;
   localparam logic [2:0] MSG_RES_PING    = 3'd2;
   localparam logic [2:0] MSG_REQ_PING    = 3'd3;
   localparam logic [2:0] MSG_REQ_CLOSE   = 3'd4;
   localparam logic [2:0] MSG_NTF_CLOSE   = 3'd5;

   // transmitted codes
   localparam logic [2:0] TX_RES_CONNECT = 3'd0;
   localparam logic [2:0] TX_NTF_CLOSE   = 3'd1;
   localparam logic [2:0] TX_RES_PING    = 3'd2;
   localparam logic [2:0] TX_REQ_PING    = 3'd3;
   localparam logic [2:0] TX_RES_CLOSE   = 3'd4;

   // register indexes
   localparam logic [1:0] CSR_PING_INTERVAL  = 2'd0;
   localparam logic [1:0] CSR_RETRY_INTERVAL = 2'd1;
   localparam logic [1:0] CSR_PING_LIMIT     = 2'd2;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 32;

   // reset values
   localparam logic [31:0] RST_PING_INTERVAL  = 32'd5000;
   localparam logic [31:0] RST_RETRY_INTERVAL = 32'd1000;
   localparam logic [7:0]  RST_PING_LIMIT     = 8'd3;
   localparam logic [31:0] START_DEADLINE     = 32'd1000;

   typedef struct packed {
      logic [31:0] ping_interval;
      logic [31:0] retry_interval;
      logic [7:0]  ping_limit;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  state;
      logic [31:0] deadline;
      logic [8:0]  missed;
   } sess_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  msg_code;
      logic [31:0] now_ms;
   } evt_type;

   typedef struct packed {
      logic       send_valid;
      logic [2:0] send_code;
      logic       break_event;
      logic       register_stub;
      logic       forward_data;
      logic [2:0] link_state;
   } res_type;

endpackage

@@ rtl/core/ulsk_if.sv @@
interface ulsk_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [2:0]  msg_code;
   logic [31:0] now_ms;

   modport source (output valid, kind, msg_code, now_ms, input ready);
   modport sink   (input valid, kind, msg_code, now_ms, output ready);
endinterface

interface ulsk_rsp_if;
   logic       valid;
   logic       ready;
   logic       send_valid;
   logic [2:0] send_code;
   logic       break_event;
   logic       register_stub;
   logic       forward_data;
   logic [2:0] link_state;

   modport source (output valid, send_valid, send_code, break_event, register_stub,
                   forward_data, link_state, input ready);
   modport sink   (input valid, send_valid, send_code, break_event, register_stub,
                   forward_data, link_state, output ready);
endinterface

@@ rtl/core/ulsk_step.sv @@
module ulsk_step
   import ulsk_pkg::*;
(
   input  sess_type cur,
   input  cfg_type  cfg,
   input  evt_type  evt,
   output sess_type nxt,
   output res_type  res
);

   logic [31:0] since_deadline;
   logic        deadline_hit;
   logic        tx;
   logic [2:0]  tx_code;
   logic        brk;
   logic        reg_stub;

   // wrap-aware now >= deadline
   assign since_deadline = evt.now_ms - cur.deadline;
   assign deadline_hit   = ~since_deadline[31];

   // next session state and outgoing message
   always_comb begin
      nxt      = cur;
      tx       = 1'b0;
      tx_code  = TX_RES_CONNECT;
      brk      = 1'b0;
      reg_stub = 1'b0;
      case (evt.kind)
         KIND_TICK: begin
            case (cur.state)
               ST_CONNECTED: begin
                  tx      = 1'b1;
                  tx_code = TX_RES_CONNECT;
               end
               ST_OPEN: begin
                  if (deadline_hit) begin
                     if (cur.missed > {1'b0, cfg.ping_limit}) begin
                        nxt.state = ST_BROKEN;
                        brk       = 1'b1;
                     end else begin
                        tx           = 1'b1;
                        tx_code      = TX_REQ_PING;
                        nxt.missed   = cur.missed + 9'd1;
                        nxt.deadline = evt.now_ms + cfg.retry_interval;
                     end
                  end
               end
               ST_CLOSING: begin
                  tx      = 1'b1;
                  tx_code = TX_NTF_CLOSE;
               end
               ST_CLOSED: begin
                  tx      = 1'b1;
                  tx_code = TX_RES_CLOSE;
               end
               default: ;
            endcase
         end
         KIND_CTRL: begin
            case (evt.msg_code)
               MSG_REQ_CONNECT: begin
                  if (cur.state inside {ST_CONNECTED, ST_INIT}) begin
                     tx        = 1'b1;
                     tx_code   = TX_RES_CONNECT;
                     nxt.state = ST_CONNECTED;
                  end
               end
               MSG_NTF_CONNECT: begin
                  if (cur.state == ST_CONNECTED) begin
                     nxt.state    = ST_OPEN;
                     reg_stub     = 1'b1;
                     nxt.deadline = evt.now_ms + cfg.ping_interval;
                     nxt.missed   = '0;
                  end
               end
               MSG_RES_PING: begin
                  nxt.deadline = evt.now_ms + cfg.ping_interval;
                  nxt.missed   = '0;
               end
               MSG_REQ_PING: begin
                  if (cur.state == ST_OPEN) begin
                     tx      = 1'b1;
                     tx_code = TX_RES_PING;
                  end
               end
               MSG_REQ_CLOSE: begin
                  tx      = 1'b1;
                  tx_code = TX_RES_CLOSE;
                  if (cur.state inside {ST_CONNECTING, ST_CONNECTED, ST_OPEN, ST_CLOSING})
                  begin
                     nxt.state = ST_CLOSED;
                     brk       = 1'b1;
                  end
               end
               MSG_NTF_CLOSE: begin
                  if (cur.state == ST_CLOSED) nxt.state = ST_NONEXIST;
               end
               default: ;
            endcase
         end
         KIND_DATA: begin
            if (cur.state == ST_OPEN) begin
               nxt.deadline = evt.now_ms + cfg.ping_interval;
               nxt.missed   = '0;
            end
         end
         default: begin
            // local close request
            if (cur.state inside {ST_INIT, ST_BROKEN}) begin
               nxt.state = ST_NONEXIST;
            end else if (cur.state inside {ST_CONNECTING, ST_CONNECTED, ST_OPEN}) begin
               nxt.state = ST_CLOSING;
               tx        = 1'b1;
               tx_code   = TX_NTF_CLOSE;
            end
         end
      endcase
   end

   // result fields
   always_comb begin
      res.send_valid    = tx;
      res.send_code     = tx ? tx_code : TX_RES_CONNECT;
      res.break_event   = brk;
      res.register_stub = reg_stub;
      res.forward_data  = (evt.kind == KIND_DATA);
      res.link_state    = nxt.state;
   end

endmodule

@@ rtl/core/udp_link_session_keepalive_fsm.sv @@
// Channel  Dir  Payload                                                    Accepted when
// req_if   in   kind, msg_code, now_ms                                     valid & ready
// rsp_if   out  send_valid, send_code, break_event, register_stub,         valid & ready
//               forward_data, link_state
// csr_*    in   csr_index, csr_wdata                                       csr_we
//
// One item per cycle sustained while rsp_if.ready stays high; each item gives exactly one result item.
// Each item passes the event register, then the result register.
// The session update is a single pass through ulsk_step between those registers.
// Reset (synchronous) empties both stages and loads the register defaults.
// A stalled result holds its register; the event stage keeps taking items
// as long as the result register drains or is empty.
`include "udp_link_session_keepalive_fsm_macros.svh"

module udp_link_session_keepalive_fsm
   import ulsk_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   ulsk_req_if.sink               req_if,
   ulsk_rsp_if.source             rsp_if,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type  cfg_ff;
   sess_type sess_ff, sess_in;
   evt_type  evt_ff;
   res_type  res_ff, res_in;
   logic     evt_valid_ff, evt_valid_in;
   logic     out_valid_ff, out_valid_in;
   logic     out_free;
   logic     evt_move;
   logic     req_take;

   // handshake between the two stages
   assign out_free     = ~out_valid_ff | rsp_if.ready;
   assign evt_move     = evt_valid_ff & out_free;
   assign req_if.ready = ~evt_valid_ff | out_free;
   assign req_take     = req_if.valid & req_if.ready;

   assign evt_valid_in = req_take | (evt_valid_ff & ~evt_move);
   assign out_valid_in = evt_move | (out_valid_ff & ~rsp_if.ready);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ping_interval  <= RST_PING_INTERVAL;
         cfg_ff.retry_interval <= RST_RETRY_INTERVAL;
         cfg_ff.ping_limit     <= RST_PING_LIMIT;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PING_INTERVAL:  cfg_ff.ping_interval  <= csr_wdata;
            CSR_RETRY_INTERVAL: cfg_ff.retry_interval <= csr_wdata;
            CSR_PING_LIMIT:     cfg_ff.ping_limit     <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // event stage
   always_ff @(posedge clock) begin
      if (reset) evt_valid_ff <= 1'b0;
      else       evt_valid_ff <= evt_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         evt_ff.kind     <= req_if.kind;
         evt_ff.msg_code <= req_if.msg_code;
         evt_ff.now_ms   <= req_if.now_ms;
      end
   end

   // session update
   ulsk_step u_step (
      .cur (sess_ff),
      .cfg (cfg_ff),
      .evt (evt_ff),
      .nxt (sess_in),
      .res (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sess_ff.state    <= ST_INIT;
         sess_ff.deadline <= START_DEADLINE;
         sess_ff.missed   <= '0;
      end else if (evt_move) begin
         sess_ff <= sess_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else       out_valid_ff <= out_valid_in;
   end

   always_ff @(posedge clock) begin
      if (evt_move) res_ff <= res_in;
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.send_valid    = res_ff.send_valid;
   assign rsp_if.send_code     = res_ff.send_code;
   assign rsp_if.break_event   = res_ff.break_event;
   assign rsp_if.register_stub = res_ff.register_stub;
   assign rsp_if.forward_data  = res_ff.forward_data;
   assign rsp_if.link_state    = res_ff.link_state;

   // checks
   `ULSK_ASSERT_NOW(a_idle_code, clock, reset, out_valid_ff && !res_ff.send_valid, res_ff.send_code == TX_RES_CONNECT, "send_code set without a message")
   `ULSK_ASSERT_NOW(a_stub_open, clock, reset, out_valid_ff && res_ff.register_stub, res_ff.link_state == ST_OPEN, "register_stub outside open state")
   `ULSK_ASSERT_NOW(a_break_state, clock, reset, out_valid_ff && res_ff.break_event, res_ff.link_state == ST_BROKEN || res_ff.link_state == ST_CLOSED, "break_event with link still up")
   `ULSK_ASSERT_NOW(a_open_entry, clock, reset, evt_move && sess_in.state == ST_OPEN && sess_ff.state != ST_OPEN, sess_ff.state == ST_CONNECTED, "link opened from a state other than connected")
   `ULSK_ASSERT_NEXT(a_state_hold, clock, reset, !evt_move, $stable(sess_ff), "session state changed without an item")

endmodule
